/* hw/rtl/tgl_pkg.sv */
// Shared types, constants and helpers for the text glyph layout core.
// Used by tgl_ctrl, tgl_dp and text_glyph_layout_wordwrap_core.
package tgl_pkg;

    typedef struct packed {
        logic        mode;
        logic [7:0]  char_code;
        logic [31:0] glyph_entry;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         tex_u;
        logic [7:0]         tex_v;
        logic [6:0]         glyph_w;
        logic [6:0]         glyph_h;
        logic [1:0]         size_code;
        logic               end_of_text;
        logic               cut_short;
    } out_item_t;

    localparam logic [2:0] CFG_LEFT   = 3'd0;
    localparam logic [2:0] CFG_TOP    = 3'd1;
    localparam logic [2:0] CFG_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_BOTTOM = 3'd3;
    localparam logic [2:0] CFG_TAB    = 3'd4;
    localparam logic [2:0] CFG_SPACE  = 3'd5;
    localparam logic [2:0] CFG_PITCH  = 3'd6;
    localparam logic [2:0] CFG_WRAP   = 3'd7;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [4:0] DIV_STEPS = 5'd17;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RES_START,
        ST_AB_WRAP,
        ST_AB_HALT,
        ST_LOOP,
        ST_WB_LOOK,
        ST_PL_A,
        ST_PL_B,
        ST_PL_C,
        ST_WS,
        ST_DIV,
        ST_TAB_DONE,
        ST_WS_POST,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic buf_push;
        logic clr_pending;
        logic idx_clr;
        logic idx_inc;
        logic ab_wrap;
        logic use_span;
        logic ab_halt;
        logic wb_read;
        logic tbl_read_wb;
        logic set_halt;
        logic place;
        logic ws_apply;
        logic div_start;
        logic div_step;
        logic tab_done;
        logic ws_wrap;
        logic clr_word;
        logic emit_end;
        logic text_clear;
    } cmd_t;

    typedef struct packed {
        logic halted;
        logic pending;
        logic is_ws;
        logic is_tab;
        logic tab_zero;
        logic last;
        logic fill_last;
        logic fill_done;
        logic y_over;
        logic visible;
        logic out_free;
        logic div_done;
        logic wrap_en;
    } status_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)
            return 16'sh7fff;
        else if (v < -18'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

/* hw/rtl/tgl_ctrl.sv */
// Sequencer for the text glyph layout core: decodes each text byte and
// steps the datapath through wrap checks, word flushes and tab division.
// Depends on tgl_pkg.
module tgl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_mode,
    output logic            in_stall,
    input  tgl_pkg::status_t st,
    output tgl_pkg::cmd_t   cmd
);

    tgl_pkg::state_t state_reg, state_next;
    logic in_res_reg, in_res_next;
    logic then_ws_reg, then_ws_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tgl_pkg::ST_IDLE;
            in_res_reg  <= 1'b0;
            then_ws_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_res_reg  <= in_res_next;
            then_ws_reg <= then_ws_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_res_next  = in_res_reg;
        then_ws_next = then_ws_reg;
        cmd          = '0;
        in_stall     = (state_reg != tgl_pkg::ST_IDLE);
        case (state_reg)
            tgl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!in_mode)
                        state_next = tgl_pkg::ST_DECODE;
                end
            end
            tgl_pkg::ST_DECODE:
            begin
                if (st.halted)
                    state_next = tgl_pkg::ST_FIN;
                else if (st.is_ws)
                begin
                    if (st.pending)
                    begin
                        in_res_next  = 1'b1;
                        then_ws_next = 1'b1;
                        state_next   = tgl_pkg::ST_RES_START;
                    end
                    else
                        state_next = tgl_pkg::ST_WS;
                end
                else if (st.pending)
                begin
                    cmd.buf_push = 1'b1;
                    if (st.fill_last || st.last)
                    begin
                        in_res_next  = 1'b1;
                        then_ws_next = 1'b0;
                        state_next   = tgl_pkg::ST_RES_START;
                    end
                    else
                        state_next = tgl_pkg::ST_FIN;
                end
                else
                begin
                    in_res_next = 1'b0;
                    state_next  = tgl_pkg::ST_PL_A;
                end
            end
            tgl_pkg::ST_RES_START:
            begin
                cmd.clr_pending = 1'b1;
                cmd.idx_clr     = 1'b1;
                state_next      = st.halted ? tgl_pkg::ST_LOOP : tgl_pkg::ST_AB_WRAP;
            end
            tgl_pkg::ST_AB_WRAP:
            begin
                cmd.ab_wrap  = 1'b1;
                cmd.use_span = in_res_reg;
                state_next   = tgl_pkg::ST_AB_HALT;
            end
            tgl_pkg::ST_AB_HALT:
            begin
                cmd.ab_halt = 1'b1;
                state_next  = in_res_reg ? tgl_pkg::ST_LOOP : tgl_pkg::ST_FIN;
            end
            tgl_pkg::ST_LOOP:
            begin
                if (!st.fill_done)
                begin
                    cmd.wb_read = 1'b1;
                    state_next  = tgl_pkg::ST_WB_LOOK;
                end
                else
                begin
                    cmd.clr_word = 1'b1;
                    if (then_ws_reg && !st.halted)
                        state_next = tgl_pkg::ST_WS;
                    else
                        state_next = tgl_pkg::ST_FIN;
                end
            end
            tgl_pkg::ST_WB_LOOK:
            begin
                cmd.tbl_read_wb = 1'b1;
                state_next      = tgl_pkg::ST_PL_A;
            end
            tgl_pkg::ST_PL_A:
            begin
                if (st.halted || st.y_over)
                begin
                    cmd.set_halt = !st.halted;
                    cmd.idx_inc  = in_res_reg;
                    state_next   = in_res_reg ? tgl_pkg::ST_LOOP : tgl_pkg::ST_FIN;
                end
                else if (!st.visible || st.out_free)
                begin
                    cmd.place  = 1'b1;
                    state_next = tgl_pkg::ST_PL_B;
                end
            end
            tgl_pkg::ST_PL_B:
            begin
                cmd.ab_wrap = 1'b1;
                state_next  = tgl_pkg::ST_PL_C;
            end
            tgl_pkg::ST_PL_C:
            begin
                cmd.ab_halt = 1'b1;
                cmd.idx_inc = in_res_reg;
                state_next  = in_res_reg ? tgl_pkg::ST_LOOP : tgl_pkg::ST_FIN;
            end
            tgl_pkg::ST_WS:
            begin
                if (st.is_tab && !st.tab_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = tgl_pkg::ST_DIV;
                end
                else
                begin
                    cmd.ws_apply = 1'b1;
                    state_next   = tgl_pkg::ST_WS_POST;
                end
            end
            tgl_pkg::ST_DIV:
            begin
                if (st.div_done)
                    state_next = tgl_pkg::ST_TAB_DONE;
                else
                    cmd.div_step = 1'b1;
            end
            tgl_pkg::ST_TAB_DONE:
            begin
                cmd.tab_done = 1'b1;
                state_next   = tgl_pkg::ST_WS_POST;
            end
            tgl_pkg::ST_WS_POST:
            begin
                if (st.wrap_en)
                begin
                    cmd.ws_wrap = 1'b1;
                    if (st.last)
                    begin
                        in_res_next  = 1'b1;
                        then_ws_next = 1'b0;
                        state_next   = tgl_pkg::ST_RES_START;
                    end
                    else
                        state_next = tgl_pkg::ST_FIN;
                end
                else
                begin
                    in_res_next = 1'b0;
                    state_next  = tgl_pkg::ST_AB_WRAP;
                end
            end
            tgl_pkg::ST_FIN:
            begin
                if (!st.last)
                    state_next = tgl_pkg::ST_IDLE;
                else if (st.out_free)
                begin
                    cmd.emit_end   = 1'b1;
                    cmd.text_clear = 1'b1;
                    state_next     = tgl_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tgl_pkg::ST_IDLE;
        endcase
    end

endmodule

/* hw/rtl/tgl_dp.sv */
// Datapath for the text glyph layout core: configuration, glyph table,
// word buffer, pen arithmetic, tab divider and output register.
// Depends on tgl_pkg.
module tgl_dp #(
    parameter int MAX_WORD    = 32,
    parameter int GLYPH_COUNT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tgl_pkg::in_item_t  in_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  tgl_pkg::cmd_t      cmd,
    output tgl_pkg::status_t   st,
    output logic               out_valid,
    input  logic               out_stall,
    output tgl_pkg::out_item_t out_data
);

    localparam int AW  = $clog2(MAX_WORD);
    localparam int FW  = $clog2(MAX_WORD + 1);
    localparam int TAW = $clog2(GLYPH_COUNT);

    // configuration
    logic signed [15:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [7:0] tab_reg;
    logic [6:0] space_reg, pitch_reg;
    logic       wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= 16'sd0;
            top_reg    <= 16'sd0;
            right_reg  <= 16'sd1023;
            bottom_reg <= 16'sd511;
            tab_reg    <= 8'd32;
            space_reg  <= 7'd4;
            pitch_reg  <= 7'd16;
            wrap_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgl_pkg::CFG_LEFT:   left_reg   <= cfg_data;
                tgl_pkg::CFG_TOP:    top_reg    <= cfg_data;
                tgl_pkg::CFG_RIGHT:  right_reg  <= cfg_data;
                tgl_pkg::CFG_BOTTOM: bottom_reg <= cfg_data;
                tgl_pkg::CFG_TAB:    tab_reg    <= cfg_data[7:0];
                tgl_pkg::CFG_SPACE:  space_reg  <= cfg_data[6:0];
                tgl_pkg::CFG_PITCH:  pitch_reg  <= cfg_data[6:0];
                tgl_pkg::CFG_WRAP:   wrap_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // glyph table and word buffer
    logic [31:0]    tbl [GLYPH_COUNT];
    logic [7:0]     wb [MAX_WORD];
    logic [31:0]    tbl_q;
    logic           oob_reg;
    logic [7:0]     wb_q;
    logic [7:0]     code_reg;
    logic           last_reg;
    logic [7:0]     rd_code;
    logic           rd_en;
    logic [FW-1:0]  fill_reg, fill_next, idx_reg, idx_next;

    assign rd_code = cmd.tbl_read_wb ? wb_q : in_data.char_code;
    assign rd_en   = cmd.accept || cmd.tbl_read_wb;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_data.mode && ({1'b0, in_data.char_code} < 9'(GLYPH_COUNT)))
            tbl[in_data.char_code[TAW-1:0]] <= in_data.glyph_entry;
        if (rd_en)
        begin
            tbl_q   <= tbl[rd_code[TAW-1:0]];
            oob_reg <= ({1'b0, rd_code} >= 9'(GLYPH_COUNT));
        end
        if (cmd.buf_push)
            wb[fill_reg[AW-1:0]] <= code_reg;
        if (cmd.wb_read)
            wb_q <= wb[idx_reg[AW-1:0]];
        if (cmd.accept)
        begin
            code_reg <= in_data.char_code;
            last_reg <= in_data.last;
        end
    end

    logic [31:0] entry;
    logic [6:0]  gw, gh;
    assign entry = oob_reg ? 32'd0 : tbl_q;
    assign gw    = entry[22:16];
    assign gh    = entry[29:23];

    // text state
    logic signed [15:0] pen_x_reg, pen_x_next, pen_y_reg, pen_y_next;
    logic [15:0] span_reg, span_next;
    logic pending_reg, pending_next, halted_reg, halted_next, open_reg, open_next;

    // tab divider
    logic signed [17:0] dx_reg, dx_next;
    logic [16:0] dmag_reg, dmag_next;
    logic [8:0]  drem_reg, drem_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic        dneg_reg, dneg_next;

    logic signed [17:0] px18, py18, wrap_lim, halt_lim, vx_lim, vy_lim, tab_x;
    logic [8:0]  rem_sh;
    logic [7:0]  rem_f;
    logic        wrap_hit;

    assign px18     = 18'(pen_x_reg);
    assign py18     = 18'(pen_y_reg);
    assign wrap_lim = 18'(right_reg) - $signed(cmd.use_span ? 18'(span_reg) : 18'd0);
    assign halt_lim = 18'(bottom_reg) - $signed(18'(pitch_reg));
    assign vx_lim   = 18'(left_reg) - $signed(18'(gw));
    assign vy_lim   = 18'(top_reg) - $signed(18'(gh));
    assign wrap_hit = px18 > wrap_lim;
    assign tab_x    = px18 + $signed(18'(tab_reg)) - 18'sd1;
    assign rem_sh   = {drem_reg[7:0], dmag_reg[16]};
    assign rem_f    = (dneg_reg && drem_reg[7:0] != 8'd0) ? tab_reg - drem_reg[7:0]
                                                         : drem_reg[7:0];

    always_comb
    begin
        pen_x_next   = pen_x_reg;
        pen_y_next   = pen_y_reg;
        span_next    = span_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        pending_next = pending_reg;
        halted_next  = halted_reg;
        open_next    = open_reg;
        dx_next      = dx_reg;
        dmag_next    = dmag_reg;
        drem_next    = drem_reg;
        dcnt_next    = dcnt_reg;
        dneg_next    = dneg_reg;

        if (cmd.accept && !in_data.mode && !open_reg)
        begin
            open_next  = 1'b1;
            pen_x_next = left_reg;
            pen_y_next = top_reg;
        end
        if (cmd.buf_push)
        begin
            fill_next = fill_reg + FW'(1);
            span_next = span_reg + 16'(gw);
        end
        if (cmd.clr_pending)
            pending_next = 1'b0;
        if (cmd.idx_clr)
            idx_next = '0;
        if (cmd.idx_inc)
            idx_next = idx_reg + FW'(1);
        if (cmd.ab_wrap && wrap_hit)
        begin
            pen_x_next = left_reg;
            pen_y_next = tgl_pkg::sat16(py18 + $signed(18'(pitch_reg)));
        end
        if (cmd.ab_halt && (py18 > halt_lim))
            halted_next = 1'b1;
        if (cmd.set_halt)
            halted_next = 1'b1;
        if (cmd.place)
            pen_x_next = tgl_pkg::sat16(px18 + $signed(18'(gw)));
        if (cmd.ws_apply)
        begin
            case (code_reg)
                tgl_pkg::CH_LF:
                begin
                    pen_x_next = left_reg;
                    pen_y_next = tgl_pkg::sat16(py18 + $signed(18'(pitch_reg)));
                end
                tgl_pkg::CH_CR:  pen_x_next = left_reg;
                tgl_pkg::CH_SP:  pen_x_next = tgl_pkg::sat16(px18 + $signed(18'(space_reg)));
                default: ;  // tab with zero spacing
            endcase
        end
        if (cmd.div_start)
        begin
            dx_next   = tab_x;
            dneg_next = tab_x[17];
            dmag_next = tab_x[17] ? 17'(-tab_x) : tab_x[16:0];
            drem_next = '0;
            dcnt_next = tgl_pkg::DIV_STEPS;
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle
            drem_next = (rem_sh >= {1'b0, tab_reg}) ? rem_sh - {1'b0, tab_reg} : rem_sh;
            dmag_next = {dmag_reg[15:0], 1'b0};
            dcnt_next = dcnt_reg - 5'd1;
        end
        if (cmd.tab_done)
            pen_x_next = tgl_pkg::sat16(dx_reg - $signed(18'(rem_f)));
        if (cmd.ws_wrap)
        begin
            pending_next = 1'b1;
            fill_next    = '0;
            span_next    = '0;
        end
        if (cmd.clr_word)
        begin
            fill_next = '0;
            span_next = '0;
        end
        if (cmd.text_clear)
        begin
            open_next    = 1'b0;
            pending_next = 1'b0;
            halted_next  = 1'b0;
            fill_next    = '0;
            span_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg   <= 16'sd0;
            pen_y_reg   <= 16'sd0;
            span_reg    <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            pending_reg <= 1'b0;
            halted_reg  <= 1'b0;
            open_reg    <= 1'b0;
            dcnt_reg    <= '0;
        end
        else
        begin
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            span_reg    <= span_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            pending_reg <= pending_next;
            halted_reg  <= halted_next;
            open_reg    <= open_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dmag_reg <= dmag_next;
        drem_reg <= drem_next;
        dneg_reg <= dneg_next;
    end

    // output register
    logic               out_valid_reg;
    tgl_pkg::out_item_t out_data_reg;
    logic               out_free, visible, emit_glyph;

    assign out_free   = !out_valid_reg || !out_stall;
    assign visible    = (px18 >= vx_lim) && (pen_x_reg <= right_reg) && (py18 >= vy_lim);
    assign emit_glyph = cmd.place && visible;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_glyph || cmd.emit_end)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_glyph)
        begin
            out_data_reg.pos_x       <= pen_x_reg;
            out_data_reg.pos_y       <= pen_y_reg;
            out_data_reg.tex_u       <= entry[7:0];
            out_data_reg.tex_v       <= entry[15:8];
            out_data_reg.glyph_w     <= gw;
            out_data_reg.glyph_h     <= gh;
            out_data_reg.size_code   <= entry[31:30];
            out_data_reg.end_of_text <= 1'b0;
            out_data_reg.cut_short   <= 1'b0;
        end
        else if (cmd.emit_end)
        begin
            out_data_reg             <= '0;
            out_data_reg.end_of_text <= 1'b1;
            out_data_reg.cut_short   <= halted_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        st.halted    = halted_reg;
        st.pending   = pending_reg;
        st.is_ws     = (code_reg == tgl_pkg::CH_TAB) || (code_reg == tgl_pkg::CH_LF) ||
                       (code_reg == tgl_pkg::CH_CR) || (code_reg == tgl_pkg::CH_SP);
        st.is_tab    = (code_reg == tgl_pkg::CH_TAB);
        st.tab_zero  = (tab_reg == 8'd0);
        st.last      = last_reg;
        st.fill_last = (fill_reg == FW'(MAX_WORD - 1));
        st.fill_done = (idx_reg >= fill_reg);
        st.y_over    = (pen_y_reg > bottom_reg);
        st.visible   = visible;
        st.out_free  = out_free;
        st.div_done  = (dcnt_reg == 5'd0);
        st.wrap_en   = wrap_reg;
    end

endmodule

/* hw/rtl/text_glyph_layout_wordwrap_core.sv */
// Text layout core: one byte per transfer in, glyph rectangles out.
// The core stays busy after each text byte; a tab also runs the 17-step
// divider, a word flush places every buffered glyph in turn, and result
// stalls hold it; one item in flight at a time. Table writes keep it idle.
// Reset clears pen, word and halt state and loads the register defaults;
// glyph table and word buffer contents are undefined until written.
module text_glyph_layout_wordwrap_core #(
    parameter int MAX_WORD    = 32,
    parameter int GLYPH_COUNT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tgl_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tgl_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    tgl_pkg::cmd_t    cmd;
    tgl_pkg::status_t st;

    tgl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (in_data.mode),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    tgl_dp #(
        .MAX_WORD    (MAX_WORD),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
